// ----- rtl/double_ended_queue_macros.svh -----
// Assertion macros for the double-ended queue.
// Included by the top level; depends on nothing else.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define DEQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DEQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DEQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define DEQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/deq_pkg.sv -----
// Types, constants and codes shared by the double-ended queue modules.
// Depends on nothing.
`default_nettype none
package deq_pkg;

    // The capacity must be a power of two: ring slots wrap by truncation.
    localparam int CAPACITY = 256;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;

    localparam int CMD_W    = 3;
    localparam int INDEX_W  = 9;
    localparam int SIZE_W   = 9;
    localparam int STATUS_W = 2;
    localparam int CMP_W    = (INDEX_W > CNT_W) ? INDEX_W : CNT_W;

    localparam int IN_TDATA_W  = ((CMD_W + DATA_W + INDEX_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DATA_W + SIZE_W + STATUS_W + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK,
        CMD_PUSH_FRONT,
        CMD_POP_BACK,
        CMD_POP_FRONT,
        CMD_READ,
        CMD_WRITE,
        CMD_INSERT,
        CMD_ERASE
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_FULL,
        ST_EMPTY,
        ST_RANGE
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_INS_SHIFT,
        S_INS_FIN,
        S_ERA_SHIFT
    } t_state;

    typedef struct packed {
        t_cmd                 cmd;
        logic [DATA_W-1:0]    value;
        logic [INDEX_W-1:0]   index;
    } t_op;

    typedef struct packed {
        logic [DATA_W-1:0]    data;
        logic [SIZE_W-1:0]    size;
        t_status              status;
    } t_res;

endpackage
`default_nettype wire

// ----- rtl/double_ended_queue.sv -----
// Top level of the double-ended queue: front decoder, command queue and back
// executor. Depends on deq_pkg, deq_front, deq_queue, deq_back and the macros.
//
// Every command item gives exactly one result item. An item passes the input
// register and the command queue before the back part takes it. The back part
// ends a push, a write, an insert at the back or a failed command in its idle
// state; a pop or a read also passes the read state (the ring store has a
// registered read). Any other insert at k shifts the entries from k up, then
// writes the value; an erase shifts those above k down, as the single write
// port of the ring store moves one entry a cycle. A two-entry command queue
// lets the input keep taking items while a command executes or a result waits.
`default_nettype none
`include "double_ended_queue_macros.svh"
module double_ended_queue (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    // cmd [2:0], value [34:3], index [43:35], zero fill above.
    input  wire  [deq_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    // data [31:0], size [40:32], status [42:41], zero fill above.
    output logic [deq_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);
    import deq_pkg::*;

    logic w_front_valid;
    logic w_front_ready;
    t_op  w_front_op;
    logic w_q_valid;
    logic w_q_pop;
    t_op  w_q_op;
    t_res w_res;

    deq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_op_valid (w_front_valid),
        .i_op_ready (w_front_ready),
        .o_op       (w_front_op)
    );

    deq_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_front_ready),
        .i_push_op    (w_front_op),
        .o_pop_valid  (w_q_valid),
        .i_pop        (w_q_pop),
        .o_pop_op     (w_q_op)
    );

    deq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (w_q_valid),
        .o_op_pop    (w_q_pop),
        .i_op        (w_q_op),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_res       (w_res)
    );

    assign o_m_tdata = OUT_TDATA_W'({w_res.status, w_res.size, w_res.data});

    `DEQ_ASSERT_IMP(a_size_bound, i_clk, i_rst_n, o_m_tvalid, w_res.size <= SIZE_W'(CAPACITY), "size above capacity")
    `DEQ_ASSERT_IMP(a_full_size, i_clk, i_rst_n, o_m_tvalid && w_res.status == ST_FULL, w_res.size == SIZE_W'(CAPACITY), "full status with room left")
    `DEQ_ASSERT_IMP(a_empty_size, i_clk, i_rst_n, o_m_tvalid && w_res.status == ST_EMPTY, w_res.size == '0, "empty status with entries held")
    `DEQ_ASSERT_IMP(a_fail_no_data, i_clk, i_rst_n, o_m_tvalid && w_res.status != ST_OK, w_res.data == '0, "failed command returned data")

endmodule
`default_nettype wire

// ----- rtl/deq_front.sv -----
// Front part: takes items from the input stream, decodes them into commands
// and holds one in a register for the command queue. Depends on deq_pkg.
`default_nettype none
module deq_front (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    input  wire  [deq_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                               o_op_valid,
    input  wire                                i_op_ready,
    output deq_pkg::t_op                       o_op
);
    import deq_pkg::*;

    logic r_valid;
    t_op  r_op;
    t_op  n_op;
    logic accept;

    assign o_s_tready = !r_valid || i_op_ready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_op_valid = r_valid;
    assign o_op       = r_op;

    always_comb begin
        n_op.cmd   = t_cmd'(i_s_tdata[CMD_W-1:0]);
        n_op.value = i_s_tdata[CMD_W +: DATA_W];
        n_op.index = i_s_tdata[CMD_W + DATA_W +: INDEX_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_op_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= n_op;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/deq_queue.sv -----
// Short command queue between the front and back parts.
// Depends on deq_pkg.
`default_nettype none
module deq_queue (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push_valid,
    output logic               o_push_ready,
    input  deq_pkg::t_op       i_push_op,
    output logic               o_pop_valid,
    input  wire                i_pop,
    output deq_pkg::t_op       o_pop_op
);
    import deq_pkg::*;

    t_op               r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              push;
    logic              pop;

    assign o_push_ready = r_cnt != QCNT_W'(QUEUE_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop_op     = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_op;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/deq_back.sv -----
// Back part: executes commands on the ring store and holds the result
// register. Depends on deq_pkg.
`default_nettype none
module deq_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_op_valid,
    output logic               o_op_pop,
    input  deq_pkg::t_op       i_op,
    output logic               o_res_valid,
    input  wire                i_res_ready,
    output deq_pkg::t_res      o_res
);
    import deq_pkg::*;

    logic [DATA_W-1:0] r_ring [CAPACITY];
    logic [DATA_W-1:0] r_rdata;

    t_state            r_state;
    t_state            n_state;
    logic [ADDR_W-1:0] r_head;
    logic [ADDR_W-1:0] n_head;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  r_ptr;
    logic [CNT_W-1:0]  n_ptr;
    t_op               r_op;
    t_op               n_op;
    t_res              r_res;
    t_res              n_res;
    logic              r_res_valid;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic              res_load;

    logic              out_free;
    logic              start;
    logic              is_full;
    logic              is_empty;
    logic [CMP_W-1:0]  idx_x;
    logic [CMP_W-1:0]  cnt_x;
    logic              ins_append;
    logic              era_last;
    logic              ins_done;
    logic              era_done;
    logic [CNT_W-1:0]  ptr_m1;
    logic [CNT_W-1:0]  ptr_m2;
    logic [CNT_W-1:0]  ptr_p1;
    logic [CNT_W-1:0]  ptr_p2;
    logic [CNT_W-1:0]  cnt_m1;
    t_status           status;

    function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                  input logic [ADDR_W-1:0] pos);
        return head + pos;
    endfunction

    assign out_free   = !r_res_valid || i_res_ready;
    assign start      = (r_state == S_IDLE) && i_op_valid && out_free;
    assign is_full    = r_count == CNT_W'(CAPACITY);
    assign is_empty   = r_count == '0;
    assign idx_x      = CMP_W'(i_op.index);
    assign cnt_x      = CMP_W'(r_count);
    assign ins_append = idx_x == cnt_x;
    assign era_last   = idx_x + CMP_W'(1) == cnt_x;
    assign ins_done   = CMP_W'(r_ptr) == CMP_W'(r_op.index) + CMP_W'(1);
    assign ptr_m1     = r_ptr - CNT_W'(1);
    assign ptr_m2     = r_ptr - CNT_W'(2);
    assign ptr_p1     = r_ptr + CNT_W'(1);
    assign ptr_p2     = r_ptr + CNT_W'(2);
    assign cnt_m1     = r_count - CNT_W'(1);
    assign era_done   = ptr_p2 == r_count;

    assign o_op_pop    = start;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        case (i_op.cmd)
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                status = is_full ? ST_FULL : ST_OK;
            end
            CMD_POP_BACK, CMD_POP_FRONT: begin
                status = is_empty ? ST_EMPTY : ST_OK;
            end
            CMD_READ, CMD_WRITE: begin
                status = (idx_x >= cnt_x) ? ST_RANGE : ST_OK;
            end
            CMD_INSERT: begin
                status = (idx_x > cnt_x) ? ST_RANGE : (is_full ? ST_FULL : ST_OK);
            end
            default: begin
                status = is_empty ? ST_EMPTY : ((idx_x >= cnt_x) ? ST_RANGE : ST_OK);
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start && status == ST_OK) begin
                    case (i_op.cmd)
                        CMD_POP_BACK, CMD_POP_FRONT, CMD_READ: begin
                            n_state = S_READ;
                        end
                        CMD_INSERT: begin
                            n_state = ins_append ? S_IDLE : S_INS_SHIFT;
                        end
                        CMD_ERASE: begin
                            n_state = era_last ? S_IDLE : S_ERA_SHIFT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            S_INS_SHIFT: begin
                n_state = ins_done ? S_INS_FIN : S_INS_SHIFT;
            end
            S_INS_FIN: begin
                n_state = S_IDLE;
            end
            S_ERA_SHIFT: begin
                n_state = era_done ? S_IDLE : S_ERA_SHIFT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = r_op.value;
        mem_raddr = '0;
        n_head    = r_head;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_op      = r_op;
        res_load  = 1'b0;
        n_res     = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op = i_op;
                    if (status != ST_OK) begin
                        res_load = 1'b1;
                    end else begin
                        case (i_op.cmd)
                            CMD_PUSH_BACK: begin
                                mem_we    = 1'b1;
                                mem_waddr = slot_of(r_head, r_count[ADDR_W-1:0]);
                                mem_wdata = i_op.value;
                                n_count   = r_count + CNT_W'(1);
                                res_load  = 1'b1;
                            end
                            CMD_PUSH_FRONT: begin
                                n_head    = r_head - ADDR_W'(1);
                                mem_we    = 1'b1;
                                mem_waddr = r_head - ADDR_W'(1);
                                mem_wdata = i_op.value;
                                n_count   = r_count + CNT_W'(1);
                                res_load  = 1'b1;
                            end
                            CMD_POP_BACK: begin
                                mem_raddr = slot_of(r_head, cnt_m1[ADDR_W-1:0]);
                                n_count   = cnt_m1;
                            end
                            CMD_POP_FRONT: begin
                                mem_raddr = r_head;
                                n_head    = r_head + ADDR_W'(1);
                                n_count   = cnt_m1;
                            end
                            CMD_READ: begin
                                mem_raddr = slot_of(r_head, i_op.index[ADDR_W-1:0]);
                            end
                            CMD_WRITE: begin
                                mem_we    = 1'b1;
                                mem_waddr = slot_of(r_head, i_op.index[ADDR_W-1:0]);
                                mem_wdata = i_op.value;
                                res_load  = 1'b1;
                            end
                            CMD_INSERT: begin
                                if (ins_append) begin
                                    mem_we    = 1'b1;
                                    mem_waddr = slot_of(r_head, i_op.index[ADDR_W-1:0]);
                                    mem_wdata = i_op.value;
                                    n_count   = r_count + CNT_W'(1);
                                    res_load  = 1'b1;
                                end else begin
                                    mem_raddr = slot_of(r_head, cnt_m1[ADDR_W-1:0]);
                                    n_ptr     = r_count;
                                end
                            end
                            default: begin
                                if (era_last) begin
                                    n_count  = cnt_m1;
                                    res_load = 1'b1;
                                end else begin
                                    n_ptr     = CNT_W'(i_op.index);
                                    mem_raddr = slot_of(r_head,
                                                        i_op.index[ADDR_W-1:0] + ADDR_W'(1));
                                end
                            end
                        endcase
                    end
                    n_res.status = status;
                end
            end
            S_READ: begin
                res_load   = 1'b1;
                n_res.data = r_rdata;
            end
            S_INS_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = slot_of(r_head, r_ptr[ADDR_W-1:0]);
                mem_wdata = r_rdata;
                mem_raddr = slot_of(r_head, ptr_m2[ADDR_W-1:0]);
                n_ptr     = ptr_m1;
            end
            S_INS_FIN: begin
                mem_we    = 1'b1;
                mem_waddr = slot_of(r_head, r_op.index[ADDR_W-1:0]);
                mem_wdata = r_op.value;
                n_count   = r_count + CNT_W'(1);
                res_load  = 1'b1;
            end
            S_ERA_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = slot_of(r_head, r_ptr[ADDR_W-1:0]);
                mem_wdata = r_rdata;
                mem_raddr = slot_of(r_head, ptr_p2[ADDR_W-1:0]);
                n_ptr     = ptr_p1;
                if (era_done) begin
                    n_count  = cnt_m1;
                    res_load = 1'b1;
                end
            end
            default: begin
                res_load = 1'b0;
            end
        endcase
        n_res.size = SIZE_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_op  <= n_op;
        if (res_load) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ring[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_ring[mem_raddr];
    end

endmodule
`default_nettype wire
